// ----- hdl/irc_pkg.sv -----
// Package for the IR pulse/space capture block: widths, constants, register
// codes, item and word types, and the length saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irc_pkg;

   // Duration width inside the block; the result port stays 24 bits wide.
   localparam int DURATION_BITS = 24;
   localparam int DUR_PORT_W    = 24;

   localparam int TIME_SEC_W  = 32;
   localparam int TIME_USEC_W = 20;
   localparam int SHORT_W     = 16;
   localparam int LONG_W      = 24;

   localparam int GAP_SECONDS  = 15;
   localparam int USEC_PER_SEC = 1000000;

   // Whole seconds that can reach the elapsed-time multiply (0 .. GAP_SECONDS).
   localparam int DSEC_W    = $clog2(GAP_SECONDS + 1);
   // Signed elapsed microseconds: gap * 1e6 plus any 20-bit usec difference.
   localparam int ELAPSED_W = $clog2(GAP_SECONDS * USEC_PER_SEC + (2 ** TIME_USEC_W)) + 1;
   localparam int UDIFF_W   = TIME_USEC_W + 1;
   localparam int CMP_W     = (ELAPSED_W - 1 > DURATION_BITS) ? ELAPSED_W - 1 : DURATION_BITS;

   localparam logic [DURATION_BITS-1:0] DUR_MAX = '1;

   // Event queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_ACTIVE_LOW  = 2'd0,
      REG_SHORT_LIMIT = 2'd1,
      REG_LONG_LIMIT  = 2'd2
   } irc_reg_type;

   typedef struct packed {
      logic               active_low;
      logic [SHORT_W-1:0] short_limit;
      logic [LONG_W-1:0]  long_limit;
   } irc_cfg_type;

   // One classified edge, as handed from front to back
   typedef struct packed {
      logic                     pulse;
      logic [DURATION_BITS-1:0] len;
   } irc_event_type;

   // One result word
   typedef struct packed {
      logic                     is_pulse;
      logic [DURATION_BITS-1:0] dur;
      logic                     last;
   } irc_word_type;

   function automatic logic [DURATION_BITS-1:0] sat_len(input logic [ELAPSED_W-2:0] v);
      if (CMP_W'(v) > CMP_W'(DUR_MAX)) begin
         return DUR_MAX;
      end
      return DURATION_BITS'(v);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/irc_front.sv -----
// Front end: accepts items, tracks reference time and polarity, classifies
// each edge and works out its length. Uses irc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irc_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           active_low,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_cmd,
   input  wire logic                           req_level,
   input  wire logic [irc_pkg::TIME_SEC_W-1:0]  req_time_sec,
   input  wire logic [irc_pkg::TIME_USEC_W-1:0] req_time_usec,
   output logic                                ev_valid,
   output irc_pkg::irc_event_type              ev_data,
   input  wire logic                           ev_full
);

   logic [irc_pkg::TIME_SEC_W-1:0]  ref_sec_ff, ref_sec_in;
   logic [irc_pkg::TIME_USEC_W-1:0] ref_usec_ff, ref_usec_in;
   logic                            polarity_ff, polarity_in;

   // stage register holding the partly worked edge
   logic                            fe_valid_ff, fe_valid_in;
   logic                            fe_max_ff, fe_max_in;
   logic                            fe_pulse_ff, fe_pulse_in;
   logic [irc_pkg::DSEC_W-1:0]      fe_dsec_ff, fe_dsec_in;
   logic [irc_pkg::UDIFF_W-1:0]     fe_udiff_ff, fe_udiff_in;

   logic                            accept;
   logic                            backward;
   logic                            gap;
   logic                            pol_new;
   logic [irc_pkg::TIME_SEC_W-1:0]  dsec;
   logic [irc_pkg::ELAPSED_W-2:0]   prod;
   logic [irc_pkg::ELAPSED_W-1:0]   elapsed;

   assign req_stall = fe_valid_ff && ev_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      backward = (req_time_sec < ref_sec_ff) ||
                 ((req_time_sec == ref_sec_ff) && (req_time_usec < ref_usec_ff));
      dsec     = req_time_sec - ref_sec_ff;
      gap      = !backward && (dsec > irc_pkg::TIME_SEC_W'(irc_pkg::GAP_SECONDS));
      // a pulse after a long gap flips polarity, so it counts as a space
      pol_new  = polarity_ff ^ (gap && (req_level == polarity_ff));

      ref_sec_in  = ref_sec_ff;
      ref_usec_in = ref_usec_ff;
      polarity_in = polarity_ff;
      fe_max_in   = backward || gap;
      fe_pulse_in = (req_level == pol_new);
      fe_dsec_in  = dsec[irc_pkg::DSEC_W-1:0];
      fe_udiff_in = {1'b0, req_time_usec} - {1'b0, ref_usec_ff};

      if (accept) begin
         ref_sec_in  = req_time_sec;
         ref_usec_in = req_time_usec;
         polarity_in = req_cmd ? active_low : pol_new;
      end

      if (accept) begin
         fe_valid_in = !req_cmd;
      end else begin
         fe_valid_in = fe_valid_ff && ev_full;
      end
   end

   // length: whole seconds times 1e6 plus the signed usec difference, clamped
   always_comb begin
      prod    = (irc_pkg::ELAPSED_W - 1)'(fe_dsec_ff * irc_pkg::USEC_PER_SEC);
      elapsed = {1'b0, prod} +
                {{(irc_pkg::ELAPSED_W - irc_pkg::UDIFF_W){fe_udiff_ff[irc_pkg::UDIFF_W-1]}},
                 fe_udiff_ff};
      ev_data.pulse = fe_pulse_ff;
      if (fe_max_ff) begin
         ev_data.len = irc_pkg::DUR_MAX;
      end else if (elapsed[irc_pkg::ELAPSED_W-1]) begin
         ev_data.len = '0;
      end else begin
         ev_data.len = irc_pkg::sat_len(elapsed[irc_pkg::ELAPSED_W-2:0]);
      end
   end

   assign ev_valid = fe_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_sec_ff  <= '0;
         ref_usec_ff <= '0;
         polarity_ff <= 1'b1;
         fe_valid_ff <= 1'b0;
      end else begin
         ref_sec_ff  <= ref_sec_in;
         ref_usec_ff <= ref_usec_in;
         polarity_ff <= polarity_in;
         fe_valid_ff <= fe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fe_max_ff   <= fe_max_in;
         fe_pulse_ff <= fe_pulse_in;
         fe_dsec_ff  <= fe_dsec_in;
         fe_udiff_ff <= fe_udiff_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/irc_fifo.sv -----
// Short event queue between the front and back parts.
// Uses irc_pkg for depth and the event type.
`timescale 1ns / 1ps
`default_nettype none

module irc_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   input  irc_pkg::irc_event_type      push_data,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        not_empty,
   output irc_pkg::irc_event_type      pop_data
);

   irc_pkg::irc_event_type             mem_ff [irc_pkg::FIFO_DEPTH];
   logic [irc_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [irc_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [irc_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;
   logic                               push;
   logic                               take;

   assign full      = (count_ff == irc_pkg::FIFO_CNT_W'(irc_pkg::FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign push      = push_valid && !full;
   assign take      = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/irc_back.sv -----
// Back end: noise filter state and the word buffer that drains up to three
// words per edge onto the result channel. Uses irc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  irc_pkg::irc_cfg_type               cfg,
   input  wire logic                          ev_valid,
   input  irc_pkg::irc_event_type             ev_data,
   output logic                               ev_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_is_pulse,
   output logic [irc_pkg::DUR_PORT_W-1:0]     rsp_duration,
   output logic                               rsp_last
);

   localparam int DB = irc_pkg::DURATION_BITS;

   logic                      holding_ff, holding_in;
   logic [DB-1:0]             held_space_ff, held_space_in;
   logic [DB:0]               pulse_sum_ff, pulse_sum_in;

   irc_pkg::irc_word_type     slot_ff [3];
   irc_pkg::irc_word_type     slot_in [3];
   irc_pkg::irc_word_type     word_new [3];
   logic [1:0]                cnt_ff, cnt_in;
   logic [1:0]                n_new;

   logic                      take;
   logic                      pop;
   logic                      long_space;
   logic [DB:0]               sum_new;
   logic [DB-1:0]             held_mid;

   function automatic logic [DB-1:0] sat1(input logic [DB:0] v);
      if (v > {1'b0, irc_pkg::DUR_MAX}) begin
         return irc_pkg::DUR_MAX;
      end
      return v[DB-1:0];
   endfunction

   function automatic logic [DB-1:0] sat2(input logic [DB+1:0] v);
      if (v > {2'b00, irc_pkg::DUR_MAX}) begin
         return irc_pkg::DUR_MAX;
      end
      return v[DB-1:0];
   endfunction

   assign take   = (cnt_ff != 2'd0) && !rsp_stall;
   // the buffer takes a new edge once it is empty or its last word leaves
   assign pop    = ev_valid && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && take));
   assign ev_pop = pop;

   always_comb begin
      sum_new    = pulse_sum_ff + {1'b0, ev_data.len};
      long_space = (32'(ev_data.len) > 32'(cfg.long_limit));
      held_mid   = sat2({2'b00, held_space_ff} + {1'b0, pulse_sum_ff});

      holding_in    = holding_ff;
      held_space_in = held_space_ff;
      pulse_sum_in  = pulse_sum_ff;
      n_new         = 2'd0;
      for (int i = 0; i < 3; i++) begin
         word_new[i] = '0;
      end

      if (ev_data.pulse && holding_ff) begin
         pulse_sum_in = sum_new;
         if (32'(sum_new) > 32'(cfg.short_limit)) begin
            word_new[0] = '{is_pulse: 1'b0, dur: held_space_ff, last: 1'b0};
            word_new[1] = '{is_pulse: 1'b1, dur: sat1(sum_new), last: 1'b1};
            n_new        = 2'd2;
            holding_in   = 1'b0;
            pulse_sum_in = '0;
         end
      end else if (!ev_data.pulse && !holding_ff && long_space) begin
         held_space_in = ev_data.len;
         holding_in    = 1'b1;
      end else if (!ev_data.pulse && holding_ff && long_space) begin
         held_space_in = sat1({1'b0, held_mid} + {1'b0, ev_data.len});
         pulse_sum_in  = '0;
      end else if (!ev_data.pulse && holding_ff) begin
         // short space ends the hold: held space, pulse sum, then the space
         word_new[0] = '{is_pulse: 1'b0, dur: held_space_ff, last: 1'b0};
         word_new[1] = '{is_pulse: 1'b1, dur: sat1(pulse_sum_ff), last: 1'b0};
         word_new[2] = '{is_pulse: 1'b0, dur: ev_data.len, last: 1'b1};
         n_new        = 2'd3;
         holding_in   = 1'b0;
         pulse_sum_in = '0;
      end else begin
         word_new[0] = '{is_pulse: ev_data.pulse, dur: ev_data.len, last: 1'b1};
         n_new       = 2'd1;
      end

      if (!pop) begin
         holding_in    = holding_ff;
         held_space_in = held_space_ff;
         pulse_sum_in  = pulse_sum_ff;
      end
   end

   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (pop) begin
         slot_in = word_new;
         cnt_in  = n_new;
      end else if (take) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holding_ff    <= 1'b0;
         held_space_ff <= '0;
         pulse_sum_ff  <= '0;
         cnt_ff        <= 2'd0;
      end else begin
         holding_ff    <= holding_in;
         held_space_ff <= held_space_in;
         pulse_sum_ff  <= pulse_sum_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign rsp_valid    = (cnt_ff != 2'd0);
   assign rsp_is_pulse = slot_ff[0].is_pulse;
   assign rsp_duration = irc_pkg::DUR_PORT_W'(slot_ff[0].dur);
   assign rsp_last     = slot_ff[0].last;

endmodule

`default_nettype wire

// ----- hdl/ir_pulse_space_capture.sv -----
// Top level of the IR pulse/space capture block: configuration registers,
// front end, event queue and back end. Uses irc_pkg, irc_front, irc_fifo, irc_back.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  req     | in        | req_valid / req_stall   | cmd, level, time_sec, time_usec
//  rsp     | out       | rsp_valid / rsp_stall   | is_pulse, duration, last
//  csr     | in/out    | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//
// One item per cycle is taken while the event queue has room; a result word
// passes the registered front stage, queue and word buffer on its way out.
// An edge that gives two or three words holds the back end until they have
// left, one word a cycle while rsp is not stalled, so the output side sets the
// sustained rate. Synchronous active-high reset clears the reference time,
// filter state and queue, sets the polarity, and loads the register defaults.
// Stalls on rsp fill the queue before req_stall is raised.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_space_capture (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input items
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_cmd,
   input  wire logic                               req_level,
   input  wire logic [irc_pkg::TIME_SEC_W-1:0]     req_time_sec,
   input  wire logic [irc_pkg::TIME_USEC_W-1:0]    req_time_usec,
   // result words
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_is_pulse,
   output logic [irc_pkg::DUR_PORT_W-1:0]          rsp_duration,
   output logic                                    rsp_last,
   // register port
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [irc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [irc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [irc_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                    pready
);

   logic                          active_low_ff, active_low_in;
   logic [irc_pkg::SHORT_W-1:0]   short_limit_ff, short_limit_in;
   logic [irc_pkg::LONG_W-1:0]    long_limit_ff, long_limit_in;

   irc_pkg::irc_cfg_type          cfg;
   irc_pkg::irc_reg_type          reg_sel;
   logic                          csr_write;

   logic                          fe_valid;
   irc_pkg::irc_event_type        fe_data;
   logic                          q_full;
   logic                          q_not_empty;
   logic                          q_pop;
   irc_pkg::irc_event_type        q_data;

   // ---- register port: zero wait states, word addressed ----
   assign pready    = 1'b1;
   assign reg_sel   = irc_pkg::irc_reg_type'(paddr[irc_pkg::CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      active_low_in  = active_low_ff;
      short_limit_in = short_limit_ff;
      long_limit_in  = long_limit_ff;
      prdata         = '0;
      case (reg_sel)
         irc_pkg::REG_ACTIVE_LOW: begin
            prdata = irc_pkg::CSR_DATA_W'(active_low_ff);
            if (csr_write) active_low_in = pwdata[0];
         end
         irc_pkg::REG_SHORT_LIMIT: begin
            prdata = irc_pkg::CSR_DATA_W'(short_limit_ff);
            if (csr_write) short_limit_in = pwdata[irc_pkg::SHORT_W-1:0];
         end
         irc_pkg::REG_LONG_LIMIT: begin
            prdata = irc_pkg::CSR_DATA_W'(long_limit_ff);
            if (csr_write) long_limit_in = pwdata[irc_pkg::LONG_W-1:0];
         end
         default: begin
            prdata = '0;  // unused address: reads zero, writes ignored
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff  <= 1'b1;
         short_limit_ff <= irc_pkg::SHORT_W'(250);
         long_limit_ff  <= irc_pkg::LONG_W'(20000);
      end else begin
         active_low_ff  <= active_low_in;
         short_limit_ff <= short_limit_in;
         long_limit_ff  <= long_limit_in;
      end
   end

   assign cfg.active_low  = active_low_ff;
   assign cfg.short_limit = short_limit_ff;
   assign cfg.long_limit  = long_limit_ff;

   // ---- front: timestamps, polarity, edge length ----
   irc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .active_low    (cfg.active_low),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_level     (req_level),
      .req_time_sec  (req_time_sec),
      .req_time_usec (req_time_usec),
      .ev_valid      (fe_valid),
      .ev_data       (fe_data),
      .ev_full       (q_full)
   );

   // ---- event queue: start commands never enter it ----
   irc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_data  (fe_data),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .pop_data   (q_data)
   );

   // ---- back: noise filter and word output ----
   irc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .ev_valid     (q_not_empty),
      .ev_data      (q_data),
      .ev_pop       (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_pulse (rsp_is_pulse),
      .rsp_duration (rsp_duration),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

// ----- test/ir_pulse_space_capture_tb.sv -----
// Self-checking bench for ir_pulse_space_capture: drives edge and start items,
// predicts the pulse/space words of each edge and checks every result word.
// Depends on irc_pkg and the block's RTL.
`timescale 1ns / 1ps

module ir_pulse_space_capture_tb;

   localparam int DRAIN_CYCLES   = 20;    // settle time after the last word due; ample for words in flight
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on any port

   typedef enum bit {
      CMD_EDGE  = 1'b0,
      CMD_START = 1'b1
   } cmd_code_type;

   // ---------------------------------------------------------------------
   // Scoreboard: own copy of registers and filter state, queue of words due
   // ---------------------------------------------------------------------
   class pulse_space_board;
      bit                            active_low  = 1'b1;
      bit [irc_pkg::SHORT_W-1:0]     short_limit = 16'd250;
      bit [irc_pkg::LONG_W-1:0]      long_limit  = 24'd20000;
      bit [irc_pkg::TIME_SEC_W-1:0]  ref_sec     = '0;
      bit [irc_pkg::TIME_USEC_W-1:0] ref_usec    = '0;
      bit                            polarity    = 1'b1;
      bit                            holding     = 1'b0;
      longint unsigned               held_space  = 0;
      longint unsigned               pulse_sum   = 0;
      irc_pkg::irc_word_type         pending_words[$];
      int                            made;
      int                            errors;
      int                            edges;
      int                            starts;
      int                            words_checked;
      int                            triples;

      function longint unsigned clip(longint unsigned v);
         return (v > irc_pkg::DUR_MAX) ? irc_pkg::DUR_MAX : v;
      endfunction

      function void set_reg(irc_pkg::irc_reg_type r, bit [irc_pkg::CSR_DATA_W-1:0] v);
         case (r)
            irc_pkg::REG_ACTIVE_LOW:  active_low  = v[0];
            irc_pkg::REG_SHORT_LIMIT: short_limit = v[irc_pkg::SHORT_W-1:0];
            irc_pkg::REG_LONG_LIMIT:  long_limit  = v[irc_pkg::LONG_W-1:0];
            default: ;
         endcase
      endfunction

      function void add_word(bit pulse, longint unsigned dur);
         irc_pkg::irc_word_type w;
         w.is_pulse = pulse;
         w.dur      = irc_pkg::DURATION_BITS'(clip(dur));
         w.last     = 1'b0;
         pending_words.push_back(w);
         made++;
      endfunction

      function void note_event(cmd_code_type cmd, bit level,
                               bit [irc_pkg::TIME_SEC_W-1:0] sec,
                               bit [irc_pkg::TIME_USEC_W-1:0] usec);
         bit [irc_pkg::TIME_SEC_W-1:0] dsec;
         longint                       span;
         longint unsigned              len;
         bit                           pulse;
         irc_pkg::irc_word_type        w;
         made = 0;
         if (cmd == CMD_START) begin
            ref_sec  = sec;
            ref_usec = usec;
            polarity = active_low;
            starts++;
            return;
         end
         edges++;
         dsec = sec - ref_sec;
         if (sec < ref_sec || (sec == ref_sec && usec < ref_usec)) begin
            len = irc_pkg::DUR_MAX;              // time ran backward
         end else if (dsec > irc_pkg::GAP_SECONDS) begin
            len = irc_pkg::DUR_MAX;              // long silence; a pulse here flips polarity
            if (level == polarity) polarity = ~polarity;
         end else begin
            span = longint'(dsec) * irc_pkg::USEC_PER_SEC + longint'(usec)
                   - longint'(ref_usec);
            if (span < 0) span = 0;
            len = clip(span);
         end
         pulse    = (level == polarity);
         ref_sec  = sec;
         ref_usec = usec;

         if (pulse && holding) begin
            pulse_sum += len;
            if (pulse_sum > short_limit) begin
               add_word(1'b0, held_space);
               add_word(1'b1, pulse_sum);
               holding   = 1'b0;
               pulse_sum = 0;
            end
         end else if (!pulse && len > long_limit) begin
            if (!holding) begin
               held_space = len;
               holding    = 1'b1;
            end else begin
               held_space = clip(held_space + pulse_sum);
               held_space = clip(held_space + len);
               pulse_sum  = 0;
            end
         end else begin
            if (!pulse && holding) begin
               add_word(1'b0, held_space);
               add_word(1'b1, pulse_sum);
               holding   = 1'b0;
               pulse_sum = 0;
            end
            add_word(pulse, len);
         end

         if (made > 0) begin
            w      = pending_words.pop_back();
            w.last = 1'b1;
            pending_words.push_back(w);
         end
         if (made == 3) triples++;
      endfunction

      function void check_word(logic is_pulse, logic [irc_pkg::DUR_PORT_W-1:0] dur,
                               logic last);
         irc_pkg::irc_word_type want;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word: is_pulse %0b duration %0d last %0b",
                     $time, is_pulse, dur, last);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         words_checked++;
         if (is_pulse !== want.is_pulse) begin
            $display("%0t: is_pulse expected %0b, got %0b", $time, want.is_pulse, is_pulse);
            errors++;
         end
         if (dur !== want.dur) begin
            $display("%0t: duration expected %0d, got %0d", $time, want.dur, dur);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last expected %0b, got %0b", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset and block ports; every input known from time zero
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid     = 1'b0;
   logic                              req_stall;
   logic                              req_cmd       = 1'b0;
   logic                              req_level     = 1'b0;
   logic [irc_pkg::TIME_SEC_W-1:0]    req_time_sec  = '0;
   logic [irc_pkg::TIME_USEC_W-1:0]   req_time_usec = '0;

   logic                              rsp_valid;
   logic                              rsp_stall     = 1'b0;
   logic                              rsp_is_pulse;
   logic [irc_pkg::DUR_PORT_W-1:0]    rsp_duration;
   logic                              rsp_last;

   logic                              psel    = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite  = 1'b0;
   logic [irc_pkg::CSR_ADDR_W-1:0]    paddr   = '0;
   logic [irc_pkg::CSR_DATA_W-1:0]    pwdata  = '0;
   logic [irc_pkg::CSR_DATA_W-1:0]    prdata;
   logic                              pready;

   pulse_space_board board;

   // Sender-side view of the timeline: last driven timestamp and edge level
   bit [irc_pkg::TIME_SEC_W-1:0]  cur_sec;
   bit [irc_pkg::TIME_USEC_W-1:0] cur_usec;
   bit                            cur_level;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int quiet_cycles  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ir_pulse_space_capture u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_level     (req_level),
      .req_time_sec  (req_time_sec),
      .req_time_usec (req_time_usec),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_pulse  (rsp_is_pulse),
      .rsp_duration  (rsp_duration),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // Receiver back-pressure, random per cycle at the current phase's rate
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Every accepted word is checked against the oldest one due
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_word(rsp_is_pulse, rsp_duration, rsp_last);
      end
   end

   // Watchdog: counts cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // One item on req; optional idle cycles first, then hold until taken
   task automatic send_item(cmd_code_type cmd, bit level, bit [irc_pkg::TIME_SEC_W-1:0] sec,
                            bit [irc_pkg::TIME_USEC_W-1:0] usec);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_level     <= level;
      req_time_sec  <= sec;
      req_time_usec <= usec;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_event(cmd, level, sec, usec);
      if (cmd == CMD_EDGE) cur_level = level;
      cur_sec  = sec;
      cur_usec = usec;
   endtask

   // Edge a given number of microseconds after the last driven timestamp
   task automatic edge_after(bit level, longint unsigned delta);
      longint unsigned              total;
      bit [irc_pkg::TIME_SEC_W-1:0] sec;
      total = longint'(cur_usec) + delta;
      sec   = cur_sec + irc_pkg::TIME_SEC_W'(total / irc_pkg::USEC_PER_SEC);
      send_item(CMD_EDGE, level, sec,
                irc_pkg::TIME_USEC_W'(total % irc_pkg::USEC_PER_SEC));
   endtask

   // Setup then access cycle; psel is dropped before returning so writes never overlap
   task automatic write_reg(irc_pkg::irc_reg_type r, bit [irc_pkg::CSR_DATA_W-1:0] v);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= irc_pkg::CSR_ADDR_W'(4 * int'(r));
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      board.set_reg(r, v);
   endtask

   // Hold the sender until every word due has come out, then let the
   // block settle, since a held space leaves work in flight with nothing due
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly alternating edges with plausible spacing; the rest is noise:
   // repeated levels, silences, backward steps, bad usec, stray starts
   task automatic random_item();
      int pick;
      bit lvl;
      pick = $urandom_range(99);
      lvl  = ($urandom_range(9) == 0) ? 1'($urandom_range(1)) : !cur_level;
      if (pick < 40)
         edge_after(lvl, $urandom_range(400, 1));
      else if (pick < 65)
         edge_after(lvl, $urandom_range(5000, 401));
      else if (pick < 85)
         edge_after(lvl, $urandom_range(200000, 15000));
      else if (pick < 89)
         edge_after(lvl, longint'($urandom_range(15, 1)) * irc_pkg::USEC_PER_SEC
                         + $urandom_range(999999));
      else if (pick < 92)
         send_item(CMD_EDGE, lvl, cur_sec + $urandom_range(1000, 16), cur_usec);
      else if (pick < 95)
         send_item(CMD_EDGE, lvl, cur_sec - $urandom_range(2),
                   irc_pkg::TIME_USEC_W'($urandom_range(999999)));
      else if (pick < 97)
         send_item(CMD_EDGE, lvl, cur_sec,
                   irc_pkg::TIME_USEC_W'($urandom_range(1048575, 1000000)));
      else
         send_item(CMD_START, lvl, cur_sec, cur_usec);
   endtask

   // Drain, reprogram, restart the timeline at a random point, then random edges
   task automatic run_phase(bit al, bit [irc_pkg::SHORT_W-1:0] sl,
                            bit [irc_pkg::LONG_W-1:0] ll,
                            int idle_pct, int stall_p, int n);
      int k;
      wait_quiet();
      write_reg(irc_pkg::REG_ACTIVE_LOW, irc_pkg::CSR_DATA_W'(al));
      write_reg(irc_pkg::REG_SHORT_LIMIT, irc_pkg::CSR_DATA_W'(sl));
      write_reg(irc_pkg::REG_LONG_LIMIT, irc_pkg::CSR_DATA_W'(ll));
      send_idle_pct = idle_pct;
      stall_pct     = stall_p;
      send_item(CMD_START, 1'($urandom_range(1)), $urandom(),
                irc_pkg::TIME_USEC_W'($urandom_range(999999)));
      for (k = 0; k < n; k++) random_item();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset register values, no idling.
      // Polarity starts active low, so level 1 is a pulse.
      send_item(CMD_START, 1'b0, 32'hFFFF_FFF0, 20'd0);
      edge_after(1'b1, 560);            // plain pulse
      edge_after(1'b0, 900);            // plain space
      edge_after(1'b0, 50000);          // long space: held
      edge_after(1'b1, 100);            // short pulse summed
      edge_after(1'b0, 30000);          // another long space folds in
      edge_after(1'b1, 300);            // sum over limit: held space + pulse sum
      edge_after(1'b0, 25000);          // held again
      edge_after(1'b1, 50);
      edge_after(1'b0, 800);            // short space while held: three words
      edge_after(1'b0, 40000);
      edge_after(1'b0, 800);            // three words with an empty pulse sum
      // exactly fifteen seconds on, usec beyond a second
      send_item(CMD_EDGE, 1'b0, 32'hFFFF_FFFF, 20'd1000000);
      send_item(CMD_EDGE, 1'b1, 32'hFFFF_FFFF, 20'd1000100);
      // seconds wrap to zero: backward pulse, saturated pulse sum
      send_item(CMD_EDGE, 1'b1, 32'd0, 20'd0);
      send_item(CMD_EDGE, 1'b0, 32'd0, 20'hFFFFF);
      // next second but elapsed negative: clamped to zero
      send_item(CMD_EDGE, 1'b0, 32'd1, 20'd0);
      // silence then pulse: polarity flips, edge counts as a space
      send_item(CMD_EDGE, 1'b1, 32'd40, 20'd0);
      send_item(CMD_EDGE, 1'b0, 32'd40, 20'd200);
      send_item(CMD_EDGE, 1'b1, 32'd40, 20'd700);
      // silence then space: no flip; second one saturates the held space
      send_item(CMD_EDGE, 1'b1, 32'd100, 20'd0);
      send_item(CMD_EDGE, 1'b1, 32'd200, 20'd0);
      send_item(CMD_EDGE, 1'b0, 32'd200, 20'd100);
      // start reloads polarity but keeps the filter holding
      send_item(CMD_START, 1'b1, 32'd300, 20'd0);
      send_item(CMD_EDGE, 1'b1, 32'd300, 20'd400);

      // Random phases across register settings and idling patterns
      run_phase(1'b0, 16'd0, 24'd0, 77, 0, 15);
      run_phase(1'b1, 16'hFFFF, 24'hFF_FFFF, 0, 77, 15);
      run_phase(1'($urandom_range(1)), irc_pkg::SHORT_W'($urandom_range(3000, 100)),
                irc_pkg::LONG_W'($urandom_range(60000, 5000)), 21, 21, 15);
      run_phase(1'b0, 16'd250, 24'd20000, 0, 0, 15);
      run_phase(1'b1, irc_pkg::SHORT_W'($urandom_range(65535)), 24'd1, 21, 21, 15);

      wait_quiet();
      if (board.pending_words.size() != 0) begin
         $display("%0t: %0d words never arrived", $time, board.pending_words.size());
         board.errors++;
      end

      $display("Covered %0d edges and %0d starts over six register settings,",
               board.edges, board.starts);
      $display("%0d words checked, %0d edges gave three words.",
               board.words_checked, board.triples);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
